>>> rtl/scd_pkg.sv
// Shared types and constants of the stereo clip distortion block.
// Used by the controller, the datapath and the top level; depends on nothing.
package scd_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = SAMPLE_WIDTH - 1;

  // Configuration port.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DRIVE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TONE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KNEE  = 3'd5;

  // Coefficients are Q1.15 and never exceed one.
  localparam int COEF_W    = 16;
  localparam int COEF_FRAC = 15;
  localparam logic [COEF_W-1:0] COEF_ONE  = 16'h8000;
  localparam logic [COEF_W-1:0] COEF_HALF = 16'h4000;

  // Drive gain 1 + 10 * drive in Q.15 needs 19 unsigned bits.
  localparam int GAIN_W = 19;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH,
    ST_DONE
  } ctrl_state_e;

  // One multiplier operation per schedule step.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LPX_L,
    OP_LPY_L,
    OP_LPX_R,
    OP_LPY_R,
    OP_GAIN_L,
    OP_GAIN_R,
    OP_KNEE_L,
    OP_KNEE_R,
    OP_DRY_L,
    OP_WIDTH,
    OP_DRY_R,
    OP_WET_L,
    OP_WET_R
  } op_e;

  // Controller to datapath. mul_op picks the operands of this cycle's product;
  // post_op consumes the product registered in the cycle before.
  typedef struct packed {
    logic load_in;
    op_e  mul_op;
    op_e  post_op;
    logic load_out;
  } cmd_t;

endpackage

>>> rtl/scd_ctrl.sv
// Sequencer of the stereo clip distortion block: handshakes and product schedule.
// Depends on scd_pkg for the command struct, the states and the operation codes.
module scd_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output scd_pkg::cmd_t   cmd_o
);

  localparam int NUM_STEPS = 13;
  localparam int STEP_W    = $clog2(NUM_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  scd_pkg::ctrl_state_e state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  scd_pkg::op_e         post_op_q;
  scd_pkg::op_e         mul_op;
  logic                 out_valid_q, out_valid_d;
  logic                 load_in, load_out;

  // A step may use a value written by the post of the step two before it.
  function automatic scd_pkg::op_e sched_op(logic [STEP_W-1:0] step);
    scd_pkg::op_e op;
    case (step)
      4'd0:    op = scd_pkg::OP_LPX_L;
      4'd1:    op = scd_pkg::OP_LPY_L;
      4'd2:    op = scd_pkg::OP_LPX_R;
      4'd3:    op = scd_pkg::OP_LPY_R;
      4'd4:    op = scd_pkg::OP_GAIN_L;
      4'd5:    op = scd_pkg::OP_GAIN_R;
      4'd6:    op = scd_pkg::OP_KNEE_L;
      4'd7:    op = scd_pkg::OP_KNEE_R;
      4'd8:    op = scd_pkg::OP_DRY_L;
      4'd9:    op = scd_pkg::OP_WIDTH;
      4'd10:   op = scd_pkg::OP_DRY_R;
      4'd11:   op = scd_pkg::OP_WET_L;
      4'd12:   op = scd_pkg::OP_WET_R;
      default: op = scd_pkg::OP_NONE;
    endcase
    return op;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scd_pkg::ST_IDLE;
      step_q      <= '0;
      post_op_q   <= scd_pkg::OP_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      post_op_q   <= mul_op;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    mul_op     = scd_pkg::OP_NONE;
    load_in    = 1'b0;
    load_out   = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      scd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_in = 1'b1;
          step_d  = '0;
          state_d = scd_pkg::ST_RUN;
        end
      end
      scd_pkg::ST_RUN: begin
        mul_op = sched_op(step_q);
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          state_d = scd_pkg::ST_FLUSH;
        end
      end
      scd_pkg::ST_FLUSH: begin
        state_d = scd_pkg::ST_DONE;
      end
      scd_pkg::ST_DONE: begin
        // The result moves to the output register once the old beat is gone.
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = scd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = scd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign cmd_o.load_in   = load_in;
  assign cmd_o.mul_op    = mul_op;
  assign cmd_o.post_op   = post_op_q;
  assign cmd_o.load_out  = load_out;

`ifndef SYNTHESIS
  a_load_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an unsent beat");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == scd_pkg::ST_RUN && step_q == '0))
    else $error("accepted beat did not start the schedule");

  a_flush_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scd_pkg::ST_FLUSH) |=> (state_q == scd_pkg::ST_DONE))
    else $error("flush not followed by done");

  a_post_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (post_op_q == $past(mul_op)))
    else $error("post operation does not follow its product");
`endif

endmodule

>>> rtl/scd_datapath.sv
// Datapath of the stereo clip distortion block: configuration, shared multiplier,
// channel state and result registers. Depends on scd_pkg.
module scd_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  scd_pkg::cmd_t                        cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [scd_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [scd_pkg::CFG_W-1:0]            cfg_wdata_i,
  input  logic signed [scd_pkg::SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [scd_pkg::SAMPLE_WIDTH-1:0] right_in_i,
  input  logic                                 frame_last_in_i,
  output logic signed [scd_pkg::SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [scd_pkg::SAMPLE_WIDTH-1:0] right_out_o,
  output logic                                 frame_last_out_o
);

  localparam int W   = scd_pkg::SAMPLE_WIDTH;
  localparam int F   = scd_pkg::FRAC_BITS;
  localparam int AW  = W + 5;                      // multiplier sample operand
  localparam int MW  = W + 4;                      // magnitude after the gain
  localparam int PW  = AW + scd_pkg::GAIN_W + 1;   // product
  localparam int GW  = scd_pkg::GAIN_W;
  localparam int CW  = scd_pkg::COEF_W;
  localparam int SHL = (F >= 15) ? F - 15 : 0;
  localparam int SHR = (F < 15) ? 15 - F : 0;

  localparam logic [MW-1:0] HALF    = MW'(1) << (F - 1);
  localparam logic [MW-1:0] NEG_LIM = MW'(1) << F;
  localparam logic [MW-1:0] POS_LIM = NEG_LIM - MW'(1);
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W - 1){1'b0}}};
  localparam logic signed [PW-1:0] PMAX = $signed((PW'(1) << F) - PW'(1));
  localparam logic signed [PW-1:0] PMIN = -$signed(PW'(1) << F);

  function automatic logic [CW-1:0] clamp_coef(logic [CW-1:0] v);
    return (v > scd_pkg::COEF_ONE) ? scd_pkg::COEF_ONE : v;
  endfunction

  function automatic logic [GW-1:0] gain_of(logic [CW-1:0] d);
    return GW'(scd_pkg::COEF_ONE) + (GW'(d) << 3) + (GW'(d) << 1);
  endfunction

  localparam logic [GW-1:0] GAIN_RESET = gain_of(scd_pkg::COEF_HALF);

  // Knee on the magnitude, sign restored, clamped to the sample range.
  function automatic logic signed [W-1:0] knee_out(logic [MW-1:0] mag, logic neg,
                                                   logic signed [PW-1:0] prod);
    logic signed [PW-1:0] ps;
    logic [MW-1:0]        m2;
    logic [MW-1:0]        negm;
    logic signed [W-1:0]  res;
    ps   = prod >>> scd_pkg::COEF_FRAC;
    m2   = (mag > HALF) ? HALF + ps[MW-1:0] : mag;
    negm = MW'(0) - m2;
    if (neg) begin
      res = (m2 > NEG_LIM) ? SMIN : negm[W-1:0];
    end else begin
      res = (m2 > POS_LIM) ? SMAX : m2[W-1:0];
    end
    return res;
  endfunction

  function automatic logic signed [W-1:0] sat_out(logic signed [PW-1:0] sum);
    logic signed [PW-1:0] s;
    logic signed [W-1:0]  res;
    s = sum >>> scd_pkg::COEF_FRAC;
    if (s > PMAX) begin
      res = SMAX;
    end else if (s < PMIN) begin
      res = SMIN;
    end else begin
      res = s[W-1:0];
    end
    return res;
  endfunction

  // Configuration; bias is stored as written, the others from values clamped to one.
  logic [GW-1:0]        gain_q;
  logic [CW-1:0]        wet_q, width_q, tone_q, knee_q;
  logic signed [CW-1:0] bias_q;

  // Channel state and intermediates; index 0 is left, 1 is right.
  logic signed [W-1:0]  lp_q   [2];
  logic signed [W-1:0]  x_q    [2];
  logic signed [W-1:0]  chan_q [2];
  logic [MW-1:0]        mag_q  [2];
  logic                 neg_q  [2];
  logic signed [PW-1:0] acc_q  [2];
  logic signed [W-1:0]  ws_q;
  logic signed [W-1:0]  res_l_q, res_r_q;
  logic                 last_q;
  logic signed [W-1:0]  out_l_q, out_r_q;
  logic                 out_last_q;

  logic signed [PW-1:0] p_q, p_d;
  logic signed [AW-1:0] op_a;
  logic [GW-1:0]        op_b;

  logic signed [47:0]   bias_w;
  logic signed [47:0]   bias_sh;
  logic signed [W-1:0]  bias_s;
  logic signed [W:0]    lr_sum, lr_dif;
  logic signed [W-1:0]  mid, side;
  logic signed [W:0]    wet_l_in, wet_r_in;
  logic signed [PW-1:0] sum_l, sum_r;
  logic signed [PW-1:0] gain_v;
  logic signed [AW-1:0] v, v_neg;
  logic [MW-1:0]        v_mag;

  // Bias moved from Q1.15 to the sample format; one of the shifts is zero.
  assign bias_w  = 48'(bias_q);
  assign bias_sh = (bias_w <<< SHL) >>> SHR;
  assign bias_s  = bias_sh[W-1:0];

  assign lr_sum   = (W + 1)'(chan_q[0]) + (W + 1)'(chan_q[1]);
  assign lr_dif   = (W + 1)'(chan_q[0]) - (W + 1)'(chan_q[1]);
  assign mid      = lr_sum[W:1];
  assign side     = lr_dif[W:1];
  assign wet_l_in = (W + 1)'(mid) + (W + 1)'(ws_q);
  assign wet_r_in = (W + 1)'(mid) - (W + 1)'(ws_q);

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_op)
      scd_pkg::OP_LPX_L: begin
        op_a = AW'(x_q[0]);
        op_b = GW'(scd_pkg::COEF_ONE - tone_q);
      end
      scd_pkg::OP_LPY_L: begin
        op_a = AW'(lp_q[0]);
        op_b = GW'(tone_q);
      end
      scd_pkg::OP_LPX_R: begin
        op_a = AW'(x_q[1]);
        op_b = GW'(scd_pkg::COEF_ONE - tone_q);
      end
      scd_pkg::OP_LPY_R: begin
        op_a = AW'(lp_q[1]);
        op_b = GW'(tone_q);
      end
      scd_pkg::OP_GAIN_L: begin
        op_a = AW'(lp_q[0]) + AW'(bias_s);
        op_b = gain_q;
      end
      scd_pkg::OP_GAIN_R: begin
        op_a = AW'(lp_q[1]) + AW'(bias_s);
        op_b = gain_q;
      end
      scd_pkg::OP_KNEE_L: begin
        op_a = $signed(AW'(mag_q[0]) - AW'(HALF));
        op_b = GW'(scd_pkg::COEF_ONE - knee_q);
      end
      scd_pkg::OP_KNEE_R: begin
        op_a = $signed(AW'(mag_q[1]) - AW'(HALF));
        op_b = GW'(scd_pkg::COEF_ONE - knee_q);
      end
      scd_pkg::OP_DRY_L: begin
        op_a = AW'(x_q[0]);
        op_b = GW'(scd_pkg::COEF_ONE - wet_q);
      end
      scd_pkg::OP_WIDTH: begin
        op_a = AW'(side);
        op_b = GW'(width_q);
      end
      scd_pkg::OP_DRY_R: begin
        op_a = AW'(x_q[1]);
        op_b = GW'(scd_pkg::COEF_ONE - wet_q);
      end
      scd_pkg::OP_WET_L: begin
        op_a = AW'(wet_l_in);
        op_b = GW'(wet_q);
      end
      scd_pkg::OP_WET_R: begin
        op_a = AW'(wet_r_in);
        op_b = GW'(wet_q);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign p_d = op_a * $signed({1'b0, op_b});

  assign sum_l  = acc_q[0] + p_q;
  assign sum_r  = acc_q[1] + p_q;
  assign gain_v = p_q >>> scd_pkg::COEF_FRAC;
  assign v      = gain_v[AW-1:0];
  assign v_neg  = -v;
  assign v_mag  = v[AW-1] ? v_neg[MW-1:0] : v[MW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RESET;
      wet_q   <= scd_pkg::COEF_HALF;
      width_q <= scd_pkg::COEF_HALF;
      tone_q  <= scd_pkg::COEF_HALF;
      bias_q  <= '0;
      knee_q  <= scd_pkg::COEF_HALF;
      lp_q[0] <= '0;
      lp_q[1] <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          scd_pkg::REG_DRIVE: gain_q  <= gain_of(clamp_coef(cfg_wdata_i));
          scd_pkg::REG_WET:   wet_q   <= clamp_coef(cfg_wdata_i);
          scd_pkg::REG_WIDTH: width_q <= clamp_coef(cfg_wdata_i);
          scd_pkg::REG_TONE:  tone_q  <= clamp_coef(cfg_wdata_i);
          scd_pkg::REG_BIAS:  bias_q  <= $signed(cfg_wdata_i);
          scd_pkg::REG_KNEE:  knee_q  <= clamp_coef(cfg_wdata_i);
          default: ;
        endcase
      end
      if (cmd_i.post_op == scd_pkg::OP_LPY_L) begin
        lp_q[0] <= W'(sum_l >>> scd_pkg::COEF_FRAC);
      end
      if (cmd_i.post_op == scd_pkg::OP_LPY_R) begin
        lp_q[1] <= W'(sum_r >>> scd_pkg::COEF_FRAC);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    if (cmd_i.load_in) begin
      x_q[0] <= left_in_i;
      x_q[1] <= right_in_i;
      last_q <= frame_last_in_i;
    end
    case (cmd_i.post_op)
      scd_pkg::OP_LPX_L, scd_pkg::OP_DRY_L: acc_q[0] <= p_q;
      scd_pkg::OP_LPX_R, scd_pkg::OP_DRY_R: acc_q[1] <= p_q;
      scd_pkg::OP_GAIN_L: begin
        mag_q[0] <= v_mag;
        neg_q[0] <= v[AW-1];
      end
      scd_pkg::OP_GAIN_R: begin
        mag_q[1] <= v_mag;
        neg_q[1] <= v[AW-1];
      end
      scd_pkg::OP_KNEE_L: chan_q[0] <= knee_out(mag_q[0], neg_q[0], p_q);
      scd_pkg::OP_KNEE_R: chan_q[1] <= knee_out(mag_q[1], neg_q[1], p_q);
      scd_pkg::OP_WIDTH:  ws_q      <= W'(p_q >>> scd_pkg::COEF_FRAC);
      scd_pkg::OP_WET_L:  res_l_q   <= sat_out(sum_l);
      scd_pkg::OP_WET_R:  res_r_q   <= sat_out(sum_r);
      default: ;
    endcase
    if (cmd_i.load_out) begin
      out_l_q    <= res_l_q;
      out_r_q    <= res_r_q;
      out_last_q <= last_q;
    end
  end

  assign left_out_o       = out_l_q;
  assign right_out_o      = out_r_q;
  assign frame_last_out_o = out_last_q;

endmodule

>>> rtl/stereo_clip_distortion.sv
// Top level of the stereo clip distortion block: sequencer plus datapath.
// Depends on scd_pkg, scd_ctrl and scd_datapath.
//
//   channel   handshake                direction  payload
//   in        in_valid_i / in_ready_o  input      left_in_i, right_in_i, frame_last_in_i
//   out       out_valid_o / out_ready_i output    left_out_o, right_out_o, frame_last_out_o
//   cfg       cfg_we_i (no wait)       input      cfg_index_i, cfg_wdata_i
//
// A frame goes through the accept, 13 products on the one shared multiplier,
// a flush step that folds in the last product and a load of the result.
// The output register holds a finished frame while the next one is computed;
// a stalled output only delays the load at the end of the following frame.
// Reset clears the lowpass memories and sets the configuration registers to their defaults.
module stereo_clip_distortion (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [scd_pkg::SAMPLE_WIDTH-1:0] left_in_i,
  input  logic signed [scd_pkg::SAMPLE_WIDTH-1:0] right_in_i,
  input  logic                                    frame_last_in_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic signed [scd_pkg::SAMPLE_WIDTH-1:0] left_out_o,
  output logic signed [scd_pkg::SAMPLE_WIDTH-1:0] right_out_o,
  output logic                                    frame_last_out_o,
  input  logic                                    cfg_we_i,
  input  logic [scd_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [scd_pkg::CFG_W-1:0]               cfg_wdata_i
);

  scd_pkg::cmd_t cmd;

  scd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  scd_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .left_in_i        (left_in_i),
    .right_in_i       (right_in_i),
    .frame_last_in_i  (frame_last_in_i),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o),
    .frame_last_out_o (frame_last_out_o)
  );

endmodule
